>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked in reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types of the MIPS subset executor.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Data memory depth in words. The index is the low bits of the address
    // sum, so the depth is a power of two.
    localparam int DATA_WORDS = 16384;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);

    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = $clog2(RF_DEPTH);
    localparam int TARGET_W = 14;

    // Opcodes and function codes.
    localparam logic [5:0] OP_RTYPE   = 6'd0;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_ADD     = 6'd32;

    // System call service numbers held in v0.
    localparam logic [31:0] SYS_PRINT_INT = 32'd1;
    localparam logic [31:0] SYS_PRINT_STR = 32'd4;
    localparam logic [31:0] SYS_EXIT      = 32'd10;

    // Registers read by a system call.
    localparam logic [RF_AW-1:0] REG_V0 = RF_AW'(2);
    localparam logic [RF_AW-1:0] REG_A0 = RF_AW'(4);

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_NONE  = 3'd0;
    localparam t_kind KIND_REG   = 3'd1;
    localparam t_kind KIND_MEM   = 3'd2;
    localparam t_kind KIND_PRINT = 3'd3;
    localparam t_kind KIND_HALT  = 3'd4;

    typedef struct packed {
        t_kind               kind;
        logic [TARGET_W-1:0] target;
        logic [31:0]         value;
    } t_result;

endpackage

>>> hw/rtl/mips_subset_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_top
// Executes add, addi, lw, sw and syscall against a register file and a
// word-addressed data memory, one result word per instruction word.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_instruction_word
//   out      output     o_out_valid / i_out_ready  o_effect_kind,
//                                                  o_target_index, o_effect_value
//
// One instruction word is taken per cycle while the output register can take a
// word and no clearing pass runs; its result moves through S1, S2 and the output register to the out channel.
// After reset a clearing pass writes zeros to all DATA_WORDS data memory
// words; o_in_ready stays low until it ends.
// When the output register is full and not taken, the whole pipeline holds,
// including the read ports of both memories, and o_in_ready drops.
//
// Pipeline:
//   accept  The rs and rt fields address the two copies of the register file.
//   S1      Operands are formed from the register file read data, overridden
//           by the pending writes in S2 and in the output register. The sum
//           is computed, the data memory is read (lw) or written (sw), and
//           halt is decided. All data memory accesses happen here, in order,
//           so loads and stores need no forwarding between them.
//   S2      Load data arrives from the data memory. The register file is
//           written as the word moves on to the output register.
//   out     The result register that the out channel shows.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_instruction_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mse_pkg::t_kind                o_effect_kind,
    output logic [mse_pkg::TARGET_W-1:0]  o_target_index,
    output logic [31:0]                   o_effect_value
);

    import mse_pkg::*;

    // Pipeline control.
    logic adv;
    logic in_fire;

    // Clearing pass over the data memory.
    logic               r_clr_busy;
    logic [DMEM_AW-1:0] r_clr_addr;

    // Stage registers.
    logic        r_s1_valid;
    logic [31:0] r_s1_instr;
    logic        r_s2_valid;
    t_result     r_s2;
    logic        r_s2_lw;
    logic        r_out_valid;
    t_result     r_out;

    // Architectural state kept in flops: register valid bits, the two
    // registers a system call reads, and the halt flag.
    logic [RF_DEPTH-1:0] r_rf_vld;
    logic [31:0]         r_v0;
    logic [31:0]         r_a0;
    logic                r_halted;

    // Decoded S1 fields.
    logic [5:0]       s1_opcode;
    logic [RF_AW-1:0] s1_rs;
    logic [RF_AW-1:0] s1_rt;
    logic [RF_AW-1:0] s1_rd;
    logic [5:0]       s1_funct;
    logic [31:0]      s1_imm;

    // S1 operands and results.
    logic [31:0]        rf_a_rdata;
    logic [31:0]        rf_b_rdata;
    logic [31:0]        s1_rs_val;
    logic [31:0]        s1_rt_val;
    logic [31:0]        s1_v0;
    logic [31:0]        s1_a0;
    logic [31:0]        s1_sum_imm;
    logic [DMEM_AW-1:0] s1_addr;
    t_result            n_s2;
    logic               n_s2_lw;
    logic               s1_sw;
    logic               s1_halt;

    // S2 results.
    logic [31:0] dmem_rdata;
    logic [31:0] s2_value;
    logic        s2_wr;
    logic        s3_wr;
    logic        rf_we;

    // Data memory write port.
    logic               dmem_we;
    logic [DMEM_AW-1:0] dmem_waddr;
    logic [31:0]        dmem_wdata;

    // The pipeline moves as a whole whenever the output register can take
    // a new word.
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv && !r_clr_busy;
    assign in_fire    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Register file: two copies so that rs and rt are read in the same cycle.
    // Both are written with the same data.
    // ------------------------------------------------------------------
    assign rf_we = adv && s2_wr;

    mse_ram #(
        .WIDTH (32),
        .DEPTH (RF_DEPTH)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.target[RF_AW-1:0]),
        .i_wdata (s2_value),
        .i_re    (in_fire),
        .i_raddr (i_instruction_word[25:21]),
        .o_rdata (rf_a_rdata)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (RF_DEPTH)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.target[RF_AW-1:0]),
        .i_wdata (s2_value),
        .i_re    (in_fire),
        .i_raddr (i_instruction_word[20:16]),
        .o_rdata (rf_b_rdata)
    );

    // ------------------------------------------------------------------
    // S1: decode, operand forwarding and execution.
    // ------------------------------------------------------------------
    assign s1_opcode = r_s1_instr[31:26];
    assign s1_rs     = r_s1_instr[25:21];
    assign s1_rt     = r_s1_instr[20:16];
    assign s1_rd     = r_s1_instr[15:11];
    assign s1_funct  = r_s1_instr[5:0];
    assign s1_imm    = {{16{r_s1_instr[15]}}, r_s1_instr[15:0]};

    // A register write is pending in S2 or was committed at the last edge,
    // too late for the read data captured at that same edge.
    assign s2_wr    = r_s2_valid && (r_s2.kind == KIND_REG);
    assign s3_wr    = r_out_valid && (r_out.kind == KIND_REG);
    assign s2_value = r_s2_lw ? dmem_rdata : r_s2.value;

    always_comb begin
        if (s2_wr && (r_s2.target == TARGET_W'(s1_rs))) begin
            s1_rs_val = s2_value;
        end else if (s3_wr && (r_out.target == TARGET_W'(s1_rs))) begin
            s1_rs_val = r_out.value;
        end else if (r_rf_vld[s1_rs]) begin
            s1_rs_val = rf_a_rdata;
        end else begin
            s1_rs_val = '0;
        end
    end

    always_comb begin
        if (s2_wr && (r_s2.target == TARGET_W'(s1_rt))) begin
            s1_rt_val = s2_value;
        end else if (s3_wr && (r_out.target == TARGET_W'(s1_rt))) begin
            s1_rt_val = r_out.value;
        end else if (r_rf_vld[s1_rt]) begin
            s1_rt_val = rf_b_rdata;
        end else begin
            s1_rt_val = '0;
        end
    end

    // The shadow copies already hold every committed write, so only S2
    // can be newer.
    assign s1_v0 = (s2_wr && (r_s2.target == TARGET_W'(REG_V0))) ? s2_value : r_v0;
    assign s1_a0 = (s2_wr && (r_s2.target == TARGET_W'(REG_A0))) ? s2_value : r_a0;

    assign s1_sum_imm = s1_rs_val + s1_imm;
    assign s1_addr    = s1_sum_imm[DMEM_AW-1:0];

    always_comb begin
        n_s2.kind   = KIND_NONE;
        n_s2.target = '0;
        n_s2.value  = '0;
        n_s2_lw     = 1'b0;
        s1_sw       = 1'b0;
        s1_halt     = 1'b0;
        if (r_s1_valid && !r_halted) begin
            case (s1_opcode)
                OP_RTYPE: begin
                    case (s1_funct)
                        FN_ADD: begin
                            if (s1_rd != '0) begin
                                n_s2.kind   = KIND_REG;
                                n_s2.target = TARGET_W'(s1_rd);
                                n_s2.value  = s1_rs_val + s1_rt_val;
                            end
                        end
                        FN_SYSCALL: begin
                            if ((s1_v0 == SYS_PRINT_INT) || (s1_v0 == SYS_PRINT_STR)) begin
                                n_s2.kind  = KIND_PRINT;
                                n_s2.value = s1_a0;
                            end else if (s1_v0 == SYS_EXIT) begin
                                n_s2.kind = KIND_HALT;
                                s1_halt   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_ADDI: begin
                    if (s1_rt != '0) begin
                        n_s2.kind   = KIND_REG;
                        n_s2.target = TARGET_W'(s1_rt);
                        n_s2.value  = s1_sum_imm;
                    end
                end
                OP_LW: begin
                    // The value arrives from the data memory in S2.
                    if (s1_rt != '0) begin
                        n_s2.kind   = KIND_REG;
                        n_s2.target = TARGET_W'(s1_rt);
                        n_s2_lw     = 1'b1;
                    end
                end
                OP_SW: begin
                    n_s2.kind   = KIND_MEM;
                    n_s2.target = TARGET_W'(s1_addr);
                    n_s2.value  = s1_rt_val;
                    s1_sw       = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Data memory. The clearing pass owns the write port until it ends;
    // no instruction is in flight during that time.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_clr_busy) begin
            dmem_we    = 1'b1;
            dmem_waddr = r_clr_addr;
            dmem_wdata = '0;
        end else begin
            dmem_we    = adv && s1_sw;
            dmem_waddr = s1_addr;
            dmem_wdata = s1_rt_val;
        end
    end

    mse_ram #(
        .WIDTH (32),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dmem_we),
        .i_waddr (dmem_waddr),
        .i_wdata (dmem_wdata),
        .i_re    (adv && n_s2_lw),
        .i_raddr (s1_addr),
        .o_rdata (dmem_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rf_vld    <= '0;
            r_v0        <= '0;
            r_a0        <= '0;
            r_halted    <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + DMEM_AW'(1);
                if (r_clr_addr == DMEM_AW'(DATA_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_valid  <= in_fire;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
                if (r_s1_valid && s1_halt) begin
                    r_halted <= 1'b1;
                end
                if (s2_wr) begin
                    r_rf_vld[r_s2.target[RF_AW-1:0]] <= 1'b1;
                    if (r_s2.target == TARGET_W'(REG_V0)) begin
                        r_v0 <= s2_value;
                    end
                    if (r_s2.target == TARGET_W'(REG_A0)) begin
                        r_a0 <= s2_value;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_instr   <= i_instruction_word;
            r_s2         <= n_s2;
            r_s2_lw      <= n_s2_lw;
            r_out.kind   <= r_s2.kind;
            r_out.target <= r_s2.target;
            r_out.value  <= s2_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_effect_kind  = r_out.kind;
    assign o_target_index = r_out.target;
    assign o_effect_value = r_out.value;

endmodule

>>> hw/rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mse_checker.sv
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the MIPS subset executor, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mse_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input mse_pkg::t_kind                o_effect_kind,
    input logic [mse_pkg::TARGET_W-1:0]  o_target_index,
    input logic [31:0]                   o_effect_value
);

    import mse_pkg::*;

    logic r_seen_halt;

    // Remembers that a halt word has been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_out_valid && i_out_ready && (o_effect_kind == KIND_HALT)) begin
            r_seen_halt <= 1'b1;
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_effect_kind) && $stable(o_target_index) && $stable(o_effect_value))

    `ASSERT_IMPLY(a_after_halt, i_clk, i_rst_n, o_out_valid && r_seen_halt, (o_effect_kind == KIND_NONE) && (o_target_index == '0) && (o_effect_value == '0))

    `ASSERT_IMPLY(a_empty_fields, i_clk, i_rst_n, o_out_valid && ((o_effect_kind == KIND_NONE) || (o_effect_kind == KIND_HALT)), (o_target_index == '0) && (o_effect_value == '0))

    `ASSERT_IMPLY(a_reg_target, i_clk, i_rst_n, o_out_valid && (o_effect_kind == KIND_REG), (o_target_index != '0) && (o_target_index[TARGET_W-1:RF_AW] == '0))

    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_ready)

endmodule

bind mips_subset_instruction_executor_top mse_checker u_mse_checker (.*);
